// File: sv/fwdc_pkg.sv
package fwdc_pkg;

   // Number format of the face geometry.
   localparam int COORD_W   = 32;
   localparam int FRAC_BITS = 16;

   // Widths of the result fields and of the floor factor.
   localparam int WEIGHT_W = FRAC_BITS + 1;
   localparam int FACTOR_W = 17;
   localparam int OUT_W    = 32;

   // Configuration register indexes and reset values.
   localparam logic REG_SMALL_THRESHOLD = 1'b0;
   localparam logic REG_FLOOR_FACTOR    = 1'b1;
   localparam logic [31:0]         THRESHOLD_RESET = 32'd1;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET    = 17'd3277;

   // Fixed weights: one, and one half.
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = WEIGHT_W'(1 << FRAC_BITS);
   localparam logic [WEIGHT_W-1:0] WEIGHT_HALF = WEIGHT_W'(1 << (FRAC_BITS - 1));

   // Divider geometry: weight, normal distance and the two reciprocals.
   localparam int WDIV_DEN_W = 65;
   localparam int WDIV_Q_W   = FRAC_BITS + 1;
   localparam int ODIV_DEN_W = COORD_W;
   localparam int ODIV_Q_W   = 33;
   localparam int RCP_DEN_W  = 34;
   localparam int RCP_Q_W    = 2 * FRAC_BITS + 1;

   // Square root of the squared centre distance.
   localparam int SQ_IN_W  = 66;
   localparam int SQ_STEPS = 33;

endpackage

// File: sv/fwdc_div_pipe.sv
module fwdc_div_pipe import fwdc_pkg::*; #(
   parameter int DEN_W = RCP_DEN_W,
   parameter int Q_W   = RCP_Q_W
) (
   input  logic             clock,
   input  logic             en,
   input  logic [DEN_W-1:0] rem0,
   input  logic [Q_W-1:0]   bits_in,
   input  logic [DEN_W-1:0] den,
   output logic [Q_W-1:0]   quot
);

   // One restoring step per stage; the numerator bits enter MSB first.
   logic [DEN_W-1:0] r_ff [Q_W];
   logic [DEN_W-1:0] d_ff [Q_W];
   logic [Q_W-1:0]   b_ff [Q_W];
   logic [Q_W-1:0]   q_ff [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      logic [DEN_W-1:0] r_prev;
      logic [DEN_W-1:0] d_prev;
      logic [Q_W-1:0]   b_prev;
      logic [Q_W-1:0]   q_prev;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic [DEN_W-1:0] r_in;
      logic [Q_W-1:0]   q_in;

      if (k == 0) begin : g_first
         assign r_prev = rem0;
         assign d_prev = den;
         assign b_prev = bits_in;
         assign q_prev = '0;
      end else begin : g_next
         assign r_prev = r_ff[k-1];
         assign d_prev = d_ff[k-1];
         assign b_prev = b_ff[k-1];
         assign q_prev = q_ff[k-1];
      end

      // Shift in the next numerator bit and subtract where the divisor fits.
      always_comb begin
         trial = {r_prev, b_prev[Q_W-1-k]};
         diff  = trial - {1'b0, d_prev};
         if (trial >= {1'b0, d_prev}) begin
            r_in = diff[DEN_W-1:0];
            q_in = q_prev | (Q_W'(1) << (Q_W - 1 - k));
         end else begin
            r_in = trial[DEN_W-1:0];
            q_in = q_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k] <= r_in;
            d_ff[k] <= d_prev;
            b_ff[k] <= b_prev;
            q_ff[k] <= q_in;
         end
      end
   end

   assign quot = q_ff[Q_W-1];

endmodule

// File: sv/face_weight_delta_coeff_unit.sv
// Channel   Direction  Handshake            Beat contents
// req       in         req_valid/req_stall  two offset vectors, area vector, |Sf|, boundary
// rsp       out        rsp_valid/rsp_stall  weight, two delta coefficients, two flags
// csr       in/out     psel/penable/pready  small threshold at 0x0, floor factor at 0x4
//
// One face is taken every cycle unless a held result stalls the pipeline; the delay from
// a taken beat to its result is set by the square root and reciprocal step chains.
// Reset is synchronous, clears the valid bits and restores the configuration defaults.
// A stalled result freezes the whole pipeline, bubbles included, and the input stalls.
module face_weight_delta_coeff_unit import fwdc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_own_to_face_x,
   input  logic signed [31:0]  req_own_to_face_y,
   input  logic signed [31:0]  req_own_to_face_z,
   input  logic signed [31:0]  req_face_to_nei_x,
   input  logic signed [31:0]  req_face_to_nei_y,
   input  logic signed [31:0]  req_face_to_nei_z,
   input  logic signed [31:0]  req_area_x,
   input  logic signed [31:0]  req_area_y,
   input  logic signed [31:0]  req_area_z,
   input  logic [31:0]         req_area_mag,
   input  logic                req_is_boundary,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [16:0]         rsp_weight,
   output logic [31:0]         rsp_delta_coeff,
   output logic [31:0]         rsp_nonorth_delta_coeff,
   output logic                rsp_delta_saturated,
   output logic                rsp_nonorth_saturated,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   // Stage map: inputs 1, d 2, products 3, dot sums 4, magnitudes 5, setup 6,
   // weight divide 7..23, root and normal divide 7..39, floor 40, divisor 41,
   // reciprocals 42..74, output 75.
   localparam int NSTAGE   = 75;
   localparam int W_DELAY  = NSTAGE - 1 - (6 + WDIV_Q_W);
   localparam logic [33:0] ORTHO_CAP = 34'h1_0000_0001;

   logic en;
   logic [NSTAGE:1] vld_ff;
   logic [NSTAGE:1] vld_in;

   logic [31:0]         thr_ff;
   logic [FACTOR_W-1:0] factor_ff;
   logic                csr_write;

   // Configuration registers.
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THRESHOLD_RESET;
         factor_ff <= FACTOR_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            REG_SMALL_THRESHOLD: thr_ff    <= pwdata;
            REG_FLOOR_FACTOR:    factor_ff <= pwdata[FACTOR_W-1:0];
            default:             thr_ff    <= thr_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_SMALL_THRESHOLD: prdata = thr_ff;
         REG_FLOOR_FACTOR:    prdata = {{(32 - FACTOR_W){1'b0}}, factor_ff};
         default:             prdata = '0;
      endcase
   end

   // The pipeline moves unless a finished result is held by the consumer.
   assign en        = !vld_ff[NSTAGE] || !rsp_stall;
   assign req_stall = !en;
   assign vld_in    = {vld_ff[NSTAGE-1:1], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: input registers.
   logic signed [31:0] s1_own_ff [3];
   logic signed [31:0] s1_nei_ff [3];
   logic signed [31:0] s1_sf_ff  [3];
   logic [31:0]        s1_area_ff;
   logic               s1_bnd_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_own_ff[0] <= req_own_to_face_x;
         s1_own_ff[1] <= req_own_to_face_y;
         s1_own_ff[2] <= req_own_to_face_z;
         s1_nei_ff[0] <= req_face_to_nei_x;
         s1_nei_ff[1] <= req_face_to_nei_y;
         s1_nei_ff[2] <= req_face_to_nei_z;
         s1_sf_ff[0]  <= req_area_x;
         s1_sf_ff[1]  <= req_area_y;
         s1_sf_ff[2]  <= req_area_z;
         s1_area_ff   <= req_area_mag;
         s1_bnd_ff    <= req_is_boundary;
      end
   end

   // Stage 2: centre distance vector; a boundary face uses the owner offset alone.
   logic signed [32:0] s2_d_ff   [3];
   logic signed [31:0] s2_own_ff [3];
   logic signed [31:0] s2_nei_ff [3];
   logic signed [31:0] s2_sf_ff  [3];
   logic [31:0]        s2_area_ff;
   logic               s2_bnd_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s2_d_ff[i]   <= s1_bnd_ff ? 33'(s1_own_ff[i])
                                      : 33'(s1_own_ff[i]) + 33'(s1_nei_ff[i]);
            s2_own_ff[i] <= s1_own_ff[i];
            s2_nei_ff[i] <= s1_nei_ff[i];
            s2_sf_ff[i]  <= s1_sf_ff[i];
         end
         s2_area_ff <= s1_area_ff;
         s2_bnd_ff  <= s1_bnd_ff;
      end
   end

   // Stage 3: component products of the three dot products and of |d| squared.
   logic signed [63:0] s3_pa_ff [3];
   logic signed [63:0] s3_pb_ff [3];
   logic signed [64:0] s3_pm_ff [3];
   logic [64:0]        s3_pq_ff [3];
   logic signed [65:0] s3_sq_in [3];
   logic [31:0]        s3_area_ff;
   logic               s3_bnd_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_sq_in[i] = 66'(s2_d_ff[i]) * 66'(s2_d_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s3_pa_ff[i] <= 64'(s2_sf_ff[i]) * 64'(s2_own_ff[i]);
            s3_pb_ff[i] <= 64'(s2_sf_ff[i]) * 64'(s2_nei_ff[i]);
            s3_pm_ff[i] <= 65'(s2_sf_ff[i]) * 65'(s2_d_ff[i]);
            s3_pq_ff[i] <= s3_sq_in[i][64:0];
         end
         s3_area_ff <= s2_area_ff;
         s3_bnd_ff  <= s2_bnd_ff;
      end
   end

   // Stage 4: dot product sums and the sum of squares.
   logic signed [64:0] s4_dota_ff;
   logic signed [64:0] s4_dotb_ff;
   logic signed [65:0] s4_dotm_ff;
   logic [65:0]        s4_ssq_ff;
   logic [31:0]        s4_area_ff;
   logic               s4_bnd_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s4_dota_ff <= 65'(s3_pa_ff[0]) + 65'(s3_pa_ff[1]) + 65'(s3_pa_ff[2]);
         s4_dotb_ff <= 65'(s3_pb_ff[0]) + 65'(s3_pb_ff[1]) + 65'(s3_pb_ff[2]);
         s4_dotm_ff <= 66'(s3_pm_ff[0]) + 66'(s3_pm_ff[1]) + 66'(s3_pm_ff[2]);
         s4_ssq_ff  <= 66'(s3_pq_ff[0]) + 66'(s3_pq_ff[1]) + 66'(s3_pq_ff[2]);
         s4_area_ff <= s3_area_ff;
         s4_bnd_ff  <= s3_bnd_ff;
      end
   end

   // Stage 5: magnitudes of the dot products.
   logic [63:0] s5_maga_ff;
   logic [63:0] s5_magb_ff;
   logic [64:0] s5_magm_ff;
   logic        s5_negm_ff;
   logic [65:0] s5_ssq_ff;
   logic [31:0] s5_area_ff;
   logic        s5_bnd_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s5_maga_ff <= s4_dota_ff[64] ? 64'(-s4_dota_ff) : 64'(s4_dota_ff);
         s5_magb_ff <= s4_dotb_ff[64] ? 64'(-s4_dotb_ff) : 64'(s4_dotb_ff);
         s5_magm_ff <= s4_dotm_ff[65] ? 65'(-s4_dotm_ff) : 65'(s4_dotm_ff);
         s5_negm_ff <= s4_dotm_ff[65];
         s5_ssq_ff  <= s4_ssq_ff;
         s5_area_ff <= s4_area_ff;
         s5_bnd_ff  <= s4_bnd_ff;
      end
   end

   // Stage 6: projected sum, small-sum test and normal distance overflow test.
   logic [64:0] s6_wsum_in;
   logic [64:0] s6_wsum_ff;
   logic        s6_small_ff;
   logic [63:0] s6_magb_ff;
   logic [64:0] s6_magm_ff;
   logic        s6_negm_ff;
   logic        s6_azero_ff;
   logic        s6_ovf_ff;
   logic [65:0] s6_ssq_ff;
   logic [31:0] s6_area_ff;
   logic        s6_bnd_ff;

   assign s6_wsum_in = 65'(s5_maga_ff) + 65'(s5_magb_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         s6_wsum_ff  <= s6_wsum_in;
         s6_small_ff <= s6_wsum_in <= 65'(thr_ff);
         s6_magb_ff  <= s5_magb_ff;
         s6_magm_ff  <= s5_magm_ff;
         s6_negm_ff  <= s5_negm_ff;
         s6_azero_ff <= s5_area_ff == '0;
         s6_ovf_ff   <= s5_magm_ff[64:33] >= s5_area_ff;
         s6_ssq_ff   <= s5_ssq_ff;
         s6_area_ff  <= s5_area_ff;
         s6_bnd_ff   <= s5_bnd_ff;
      end
   end

   // Weight divide: |Sf.dNei| * 2^F over the projected sum.
   logic [WDIV_Q_W-1:0] wq;

   fwdc_div_pipe #(
      .DEN_W (WDIV_DEN_W),
      .Q_W   (WDIV_Q_W)
   ) u_wdiv (
      .clock   (clock),
      .en      (en),
      .rem0    (WDIV_DEN_W'(s6_magb_ff[63:1])),
      .bits_in ({s6_magb_ff[0], {(WDIV_Q_W - 1){1'b0}}}),
      .den     (s6_wsum_ff),
      .quot    (wq)
   );

   // Normal distance divide: Sf.d over |Sf|.
   logic [ODIV_Q_W-1:0] oq;

   fwdc_div_pipe #(
      .DEN_W (ODIV_DEN_W),
      .Q_W   (ODIV_Q_W)
   ) u_odiv (
      .clock   (clock),
      .en      (en),
      .rem0    (s6_magm_ff[64:33]),
      .bits_in (s6_magm_ff[32:0]),
      .den     (s6_area_ff),
      .quot    (oq)
   );

   // Integer square root of |d| squared, one result bit per stage.
   logic [SQ_IN_W-1:0]  sq_rem_ff  [SQ_STEPS];
   logic [SQ_STEPS-1:0] sq_root_ff [SQ_STEPS];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      localparam int B = SQ_STEPS - 1 - k;
      logic [SQ_IN_W-1:0]  rem_prev;
      logic [SQ_STEPS-1:0] root_prev;
      logic [SQ_IN_W:0]    trial;
      logic [SQ_IN_W-1:0]  rem_in;
      logic [SQ_STEPS-1:0] root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = s6_ssq_ff;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = sq_rem_ff[k-1];
         assign root_prev = sq_root_ff[k-1];
      end

      // Trial is (root + 2^B)^2 - root^2, since root has no bits below B+1.
      always_comb begin
         trial = ((SQ_IN_W + 1)'(root_prev) << (B + 1)) + ((SQ_IN_W + 1)'(1) << (2 * B));
         if (trial <= (SQ_IN_W + 1)'(rem_prev)) begin
            rem_in  = rem_prev - trial[SQ_IN_W-1:0];
            root_in = root_prev | (SQ_STEPS'(1) << B);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_rem_ff[k]  <= rem_in;
            sq_root_ff[k] <= root_in;
         end
      end
   end

   // Side flags travelling alongside the dividers.
   logic [1:0] wfl_ff [WDIV_Q_W];
   logic [2:0] ofl_ff [ODIV_Q_W];

   always_ff @(posedge clock) begin
      if (en) begin
         wfl_ff[0] <= {s6_small_ff, s6_bnd_ff};
         for (int k = 1; k < WDIV_Q_W; k++) begin
            wfl_ff[k] <= wfl_ff[k-1];
         end
         ofl_ff[0] <= {s6_negm_ff, s6_azero_ff, s6_ovf_ff};
         for (int k = 1; k < ODIV_Q_W; k++) begin
            ofl_ff[k] <= ofl_ff[k-1];
         end
      end
   end

   // Weight selection once the divide is done, then a delay to the output.
   logic [WEIGHT_W-1:0] w_in;
   logic [WEIGHT_W-1:0] wdl_ff [W_DELAY];

   always_comb begin
      if (wfl_ff[WDIV_Q_W-1][0]) begin
         w_in = WEIGHT_ONE;
      end else if (wfl_ff[WDIV_Q_W-1][1]) begin
         w_in = WEIGHT_HALF;
      end else begin
         w_in = wq;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wdl_ff[0] <= w_in;
         for (int k = 1; k < W_DELAY; k++) begin
            wdl_ff[k] <= wdl_ff[k-1];
         end
      end
   end

   // Stage 40: limited normal distance and the floor distance.
   logic [32:0] cdist;
   logic [2:0]  ofl;
   logic [33:0] s40_ortho_in;
   logic [49:0] s40_prod;
   logic [33:0] s40_ortho_ff;
   logic [33:0] s40_flr_ff;
   logic [32:0] s40_dist_ff;

   assign cdist    = sq_root_ff[SQ_STEPS-1];
   assign ofl      = ofl_ff[ODIV_Q_W-1];
   assign s40_prod = 50'(factor_ff) * 50'(cdist);

   always_comb begin
      if (ofl[2] || ofl[1]) begin
         s40_ortho_in = '0;
      end else if (ofl[0] || (34'(oq) > ORTHO_CAP)) begin
         s40_ortho_in = ORTHO_CAP;
      end else begin
         s40_ortho_in = 34'(oq);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s40_ortho_ff <= s40_ortho_in;
         s40_flr_ff   <= s40_prod[49:16];
         s40_dist_ff  <= cdist;
      end
   end

   // Stage 41: divisor of the non-orthogonal coefficient.
   logic [33:0] s41_div_ff;
   logic [33:0] s41_dist_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s41_div_ff  <= (s40_ortho_ff > s40_flr_ff) ? s40_ortho_ff : s40_flr_ff;
         s41_dist_ff <= 34'(s40_dist_ff);
      end
   end

   // Reciprocals 2^(2F) / divisor.
   logic [RCP_Q_W-1:0] dq;
   logic [RCP_Q_W-1:0] nq;

   fwdc_div_pipe #(
      .DEN_W (RCP_DEN_W),
      .Q_W   (RCP_Q_W)
   ) u_drcp (
      .clock   (clock),
      .en      (en),
      .rem0    ('0),
      .bits_in ({1'b1, {(RCP_Q_W - 1){1'b0}}}),
      .den     (s41_dist_ff),
      .quot    (dq)
   );

   fwdc_div_pipe #(
      .DEN_W (RCP_DEN_W),
      .Q_W   (RCP_Q_W)
   ) u_nrcp (
      .clock   (clock),
      .en      (en),
      .rem0    ('0),
      .bits_in ({1'b1, {(RCP_Q_W - 1){1'b0}}}),
      .den     (s41_div_ff),
      .quot    (nq)
   );

   // A divisor of zero or one gives a reciprocal beyond the output range.
   logic [1:0] sfl_ff [RCP_Q_W];

   always_ff @(posedge clock) begin
      if (en) begin
         sfl_ff[0] <= {s41_dist_ff <= 34'd1, s41_div_ff <= 34'd1};
         for (int k = 1; k < RCP_Q_W; k++) begin
            sfl_ff[k] <= sfl_ff[k-1];
         end
      end
   end

   // Stage 75: output register.
   logic [1:0] sfl;

   assign sfl = sfl_ff[RCP_Q_W-1];

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_weight              <= wdl_ff[W_DELAY-1];
         rsp_delta_coeff         <= sfl[1] ? '1 : dq[OUT_W-1:0];
         rsp_nonorth_delta_coeff <= sfl[0] ? '1 : nq[OUT_W-1:0];
         rsp_delta_saturated     <= sfl[1];
         rsp_nonorth_saturated   <= sfl[0];
      end
   end

   assign rsp_valid = vld_ff[NSTAGE];

`ifndef SYNTHESIS
   // The weight is a fraction of one.
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weight <= WEIGHT_ONE))
      else $error("weight above one");

   // A saturated coefficient reads as all ones.
   a_delta_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_delta_saturated) |-> (rsp_delta_coeff == '1))
      else $error("saturated delta coefficient not at maximum");

   a_nonorth_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_nonorth_saturated) |-> (rsp_nonorth_delta_coeff == '1))
      else $error("saturated non-orthogonal coefficient not at maximum");

   // An unsaturated reciprocal has a divisor of at least two.
   a_delta_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_delta_saturated) |-> (rsp_delta_coeff <= 32'h8000_0000))
      else $error("unsaturated delta coefficient out of range");
`endif

endmodule
